// File: rtl/btn_dbc_pkg.sv
// Shared types, widths and codes for the button debounce and press classifier.
`default_nettype none

package btn_dbc_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int COUNT_WIDTH = 8;
    localparam int DB_CFG_WIDTH = 8;

    localparam int CLASS_WIDTH = 2;

    localparam int IN_FIELD_BITS  = 1 + TIME_WIDTH;
    localparam int OUT_FIELD_BITS = 2 + CLASS_WIDTH + TIME_WIDTH;
    localparam int IN_TDATA_WIDTH  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESS_DB   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE_DB = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_TH   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORMAL_TH  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_TH    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD     = 3'd5;

    // Press classes.
    localparam logic [CLASS_WIDTH-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLASS_WIDTH-1:0] CLS_SHORT  = 2'd1;
    localparam logic [CLASS_WIDTH-1:0] CLS_NORMAL = 2'd2;
    localparam logic [CLASS_WIDTH-1:0] CLS_LONG   = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [DB_CFG_WIDTH-1:0] PRESS_DB_RST   = 8'd4;
    localparam logic [DB_CFG_WIDTH-1:0] RELEASE_DB_RST = 8'd4;
    localparam logic [TIME_WIDTH-1:0]   SHORT_TH_RST   = TIME_WIDTH'(50);
    localparam logic [TIME_WIDTH-1:0]   NORMAL_TH_RST  = TIME_WIDTH'(1000);
    localparam logic [TIME_WIDTH-1:0]   LONG_TH_RST    = TIME_WIDTH'(3000);
    localparam logic [TIME_WIDTH-1:0]   PERIOD_RST     = TIME_WIDTH'(64'hFFFF_FFFE);

    typedef struct packed {
        logic [TIME_WIDTH-1:0] short_th;
        logic [TIME_WIDTH-1:0] normal_th;
        logic [TIME_WIDTH-1:0] long_th;
        logic [TIME_WIDTH-1:0] period;
    } t_time_cfg;

endpackage

`default_nettype wire

// File: rtl/btn_dbc_measure.sv
// Press duration with timer rollover, and its classification against thresholds.
`default_nettype none

module btn_dbc_measure (
    input  wire btn_dbc_pkg::t_time_cfg                  i_cfg,
    input  wire logic [btn_dbc_pkg::TIME_WIDTH-1:0]      i_stamp,
    input  wire logic [btn_dbc_pkg::TIME_WIDTH-1:0]      i_now,
    output logic      [btn_dbc_pkg::TIME_WIDTH-1:0]      o_duration,
    output logic      [btn_dbc_pkg::CLASS_WIDTH-1:0]     o_class
);
    import btn_dbc_pkg::*;

    logic [TIME_WIDTH-1:0] w_direct;
    logic [TIME_WIDTH-1:0] w_wrapped;

    // Both candidates are formed in parallel; the compare only selects.
    assign w_direct  = i_now - i_stamp;
    assign w_wrapped = i_cfg.period - i_stamp + i_now + TIME_WIDTH'(1);
    assign o_duration = (i_now > i_stamp) ? w_direct : w_wrapped;

    always_comb begin
        if (o_duration == '0) begin
            o_class = CLS_NONE;
        end else if (o_duration > i_cfg.long_th) begin
            o_class = CLS_LONG;
        end else if (o_duration > i_cfg.normal_th) begin
            o_class = CLS_NORMAL;
        end else if (o_duration > i_cfg.short_th) begin
            o_class = CLS_SHORT;
        end else begin
            o_class = CLS_NONE;
        end
    end

endmodule

`default_nettype wire

// File: rtl/button_debounce_press_classifier.sv
// Top level of the button debounce and press classifier.
`default_nettype none

// One poll per input transaction gives exactly one result transaction. The block
// takes a poll in every cycle while the output is not stalled: a poll passes an
// input register and then a result register, and the debounce counter, the
// accepted level and the press stamp are updated as the poll moves from the one
// register to the other. The configuration port is always ready; write it only
// while no poll is in flight.
module button_debounce_press_classifier (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    // Configuration writes.
    input  wire logic                                        i_cfg_valid,
    output logic                                             o_cfg_ready,
    input  wire logic [btn_dbc_pkg::CFG_INDEX_WIDTH-1:0]     i_cfg_index,
    input  wire logic [btn_dbc_pkg::CFG_DATA_WIDTH-1:0]      i_cfg_data,
    // Poll stream.
    input  wire logic                                        i_s_tvalid,
    output logic                                             o_s_tready,
    // tdata from bit 0: raw_level, tick_now, zero padding.
    input  wire logic [btn_dbc_pkg::IN_TDATA_WIDTH-1:0]      i_s_tdata,
    // Result stream.
    output logic                                             o_m_tvalid,
    input  wire logic                                        i_m_tready,
    // tdata from bit 0: debounced, changed, press_class, press_duration, zero padding.
    output logic      [btn_dbc_pkg::OUT_TDATA_WIDTH-1:0]     o_m_tdata
);
    import btn_dbc_pkg::*;

    // Configuration registers.
    logic [DB_CFG_WIDTH-1:0] r_press_db;
    logic [DB_CFG_WIDTH-1:0] r_release_db;
    t_time_cfg               r_time_cfg;

    // Input register.
    logic                  r_in_valid;
    logic                  r_in_raw;
    logic [TIME_WIDTH-1:0] r_in_now;

    // Block state.
    logic                   r_level;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [TIME_WIDTH-1:0]  r_stamp;

    // Result register.
    logic                   r_out_valid;
    logic                   r_out_level;
    logic                   r_out_changed;
    logic [CLASS_WIDTH-1:0] r_out_class;
    logic [TIME_WIDTH-1:0]  r_out_duration;

    logic                   w_adv;
    logic                   w_accept;
    logic                   n_level;
    logic                   n_changed;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [TIME_WIDTH-1:0]  w_duration;
    logic [CLASS_WIDTH-1:0] w_class;

    assign o_cfg_ready = 1'b1;

    assign w_adv      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Debounce: reload while the raw level agrees, otherwise count down and
    // accept the new level once the count reaches one or zero.
    always_comb begin
        n_level   = r_level;
        n_changed = 1'b0;
        if (r_in_raw == r_level) begin
            n_count = r_level ? COUNT_WIDTH'(r_release_db) : COUNT_WIDTH'(r_press_db);
        end else if (r_count <= COUNT_WIDTH'(1)) begin
            n_level   = r_in_raw;
            n_changed = 1'b1;
            n_count   = r_in_raw ? COUNT_WIDTH'(r_release_db) : COUNT_WIDTH'(r_press_db);
        end else begin
            n_count = r_count - COUNT_WIDTH'(1);
        end
    end

    btn_dbc_measure u_measure (
        .i_cfg      (r_time_cfg),
        .i_stamp    (r_stamp),
        .i_now      (r_in_now),
        .o_duration (w_duration),
        .o_class    (w_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_db           <= PRESS_DB_RST;
            r_release_db         <= RELEASE_DB_RST;
            r_time_cfg.short_th  <= SHORT_TH_RST;
            r_time_cfg.normal_th <= NORMAL_TH_RST;
            r_time_cfg.long_th   <= LONG_TH_RST;
            r_time_cfg.period    <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRESS_DB:   r_press_db           <= i_cfg_data[DB_CFG_WIDTH-1:0];
                REG_RELEASE_DB: r_release_db         <= i_cfg_data[DB_CFG_WIDTH-1:0];
                REG_SHORT_TH:   r_time_cfg.short_th  <= TIME_WIDTH'(i_cfg_data);
                REG_NORMAL_TH:  r_time_cfg.normal_th <= TIME_WIDTH'(i_cfg_data);
                REG_LONG_TH:    r_time_cfg.long_th   <= TIME_WIDTH'(i_cfg_data);
                REG_PERIOD:     r_time_cfg.period    <= TIME_WIDTH'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= 1'b0;
            r_count     <= COUNT_WIDTH'(PRESS_DB_RST);
            r_stamp     <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_level <= n_level;
                r_count <= n_count;
                if (n_changed && n_level) begin
                    r_stamp <= r_in_now;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_raw <= i_s_tdata[0];
            r_in_now <= i_s_tdata[TIME_WIDTH:1];
        end
        if (w_adv) begin
            r_out_level   <= n_level;
            r_out_changed <= n_changed;
            if (n_changed && !n_level) begin
                r_out_class    <= w_class;
                r_out_duration <= w_duration;
            end else begin
                r_out_class    <= CLS_NONE;
                r_out_duration <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_WIDTH'({r_out_duration, r_out_class,
                                          r_out_changed, r_out_level});

`ifndef SYNTHESIS
    // The accepted level moves exactly when a change is reported.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ((r_level != $past(r_level)) == r_out_changed))
        else $error("level flip and changed flag disagree");

    // A result that is not a release carries no class and no duration.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !(r_out_changed && !r_out_level)) |->
        (r_out_class == CLS_NONE && r_out_duration == '0))
        else $error("class or duration reported outside a release");

    // A classified press always has a non-zero duration.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_class != CLS_NONE) |-> (r_out_duration != '0))
        else $error("classified press with zero duration");

    // A poll held in the input register is not dropped while the output stalls.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_now)))
        else $error("stalled poll lost");
`endif

endmodule

`default_nettype wire
